@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker file of the line splitter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is disabled while reset is high.
`define LTS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define LTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/lts_pkg.sv @@
// Types and constants shared by the line splitter modules.
`default_nettype none

package lts_pkg;

  // Stream characters
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Bit positions in accept_mask
  localparam int ACC_CR   = 0;
  localparam int ACC_LF   = 1;
  localparam int ACC_CRLF = 2;

  // Terminator codes
  localparam logic [1:0] TERM_NONE = 2'd0;
  localparam logic [1:0] TERM_LF   = 2'd1;
  localparam logic [1:0] TERM_CR   = 2'd2;
  localparam logic [1:0] TERM_CRLF = 2'd3;

  // Action kinds decoded from one input word
  localparam logic [1:0] OP_NONE    = 2'd0;
  localparam logic [1:0] OP_CONTENT = 2'd1;
  localparam logic [1:0] OP_CLOSE   = 2'd2;

  // Configuration register indexes
  localparam int         CFG_IDX_W       = 4;
  localparam logic [3:0] REG_ACCEPT_MASK = 4'd0;
  localparam logic [3:0] REG_LINE_LIMIT  = 4'd1;

  // Configuration reset values
  localparam logic [2:0]  ACCEPT_MASK_RST = 3'd7;
  localparam logic [12:0] LINE_LIMIT_RST  = 13'd8191;

  // Result queue size
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] term;
  } op_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       line_done;
    logic [1:0] terminator;
    logic       too_long;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/lts_step.sv @@
// Per-word decode: next line state and up to two result words.
`default_nettype none

module lts_step #(
  parameter int MAX_LINE = 8192,
  parameter int CNT_W    = $clog2(MAX_LINE)
) (
  input  logic                   [7:0]       in_byte,
  input  logic                               end_of_stream,
  input  logic                   [2:0]       accept_mask,
  input  logic                   [12:0]      line_limit,
  input  logic                               pending_cr,
  input  logic                   [CNT_W-1:0] line_count,
  input  logic                               overflowed,
  output logic                               pending_cr_next,
  output logic                   [CNT_W-1:0] line_count_next,
  output logic                               overflowed_next,
  output lts_pkg::result_t                   res0,
  output lts_pkg::result_t                   res1,
  output logic                               push0,
  output logic                               push1
);

  localparam int LW = (CNT_W > 13) ? CNT_W : 13;
  localparam logic [LW-1:0] CAP = LW'(MAX_LINE - 1);

  logic [LW-1:0]    lim_wide;
  logic [CNT_W-1:0] lim;
  lts_pkg::op_t     bare_op;
  lts_pkg::op_t     plain_op;
  logic             plain_pcr;
  lts_pkg::op_t     op_a;
  lts_pkg::op_t     op_b;
  logic [CNT_W-1:0] cnt_mid;
  logic             ovf_mid;
  lts_pkg::result_t ra;
  lts_pkg::result_t rb;
  logic             emit_a;
  logic             emit_b;

  // Limit in force: smaller of the register and the storage cap
  always_comb begin
    lim_wide = (LW'(line_limit) < CAP) ? LW'(line_limit) : CAP;
    lim      = lim_wide[CNT_W-1:0];
  end

  // Decode a held CR and the new byte into at most two actions
  always_comb begin
    bare_op.data = lts_pkg::CH_CR;
    if (accept_mask[lts_pkg::ACC_CR]) begin
      bare_op.kind = lts_pkg::OP_CLOSE;
      bare_op.term = lts_pkg::TERM_CR;
    end else begin
      bare_op.kind = lts_pkg::OP_CONTENT;
      bare_op.term = lts_pkg::TERM_NONE;
    end

    plain_op.data = in_byte;
    plain_op.term = lts_pkg::TERM_NONE;
    plain_op.kind = lts_pkg::OP_CONTENT;
    plain_pcr     = 1'b0;
    if (in_byte == lts_pkg::CH_CR &&
        (accept_mask[lts_pkg::ACC_CR] || accept_mask[lts_pkg::ACC_CRLF])) begin
      if (accept_mask[lts_pkg::ACC_CRLF]) begin
        plain_op.kind = lts_pkg::OP_NONE;
        plain_pcr     = 1'b1;
      end else begin
        plain_op.kind = lts_pkg::OP_CLOSE;
        plain_op.term = lts_pkg::TERM_CR;
      end
    end else if (in_byte == lts_pkg::CH_LF && accept_mask[lts_pkg::ACC_LF]) begin
      plain_op.kind = lts_pkg::OP_CLOSE;
      plain_op.term = lts_pkg::TERM_LF;
    end

    op_a.kind = lts_pkg::OP_NONE;
    op_a.data = 8'h00;
    op_a.term = lts_pkg::TERM_NONE;
    op_b      = op_a;
    pending_cr_next = pending_cr;

    if (end_of_stream) begin
      pending_cr_next = 1'b0;
      if (pending_cr) begin
        op_a = bare_op;
      end
      // A CR kept as content always leaves an open line to close
      if ((pending_cr && !accept_mask[lts_pkg::ACC_CR]) ||
          (!pending_cr && (line_count != '0 || overflowed))) begin
        op_b.kind = lts_pkg::OP_CLOSE;
        op_b.term = lts_pkg::TERM_NONE;
      end
    end else if (pending_cr) begin
      if (in_byte == lts_pkg::CH_LF) begin
        pending_cr_next = 1'b0;
        op_a.kind = lts_pkg::OP_CLOSE;
        op_a.term = lts_pkg::TERM_CRLF;
      end else begin
        pending_cr_next = plain_pcr;
        op_a = bare_op;
        op_b = plain_op;
      end
    end else begin
      pending_cr_next = plain_pcr;
      op_b = plain_op;
    end
  end

  // Apply both actions in order to the line count and overflow flag
  always_comb begin
    emit_a  = 1'b0;
    ra      = '0;
    cnt_mid = line_count;
    ovf_mid = overflowed;
    case (op_a.kind)
      lts_pkg::OP_CONTENT: begin
        if (overflowed || line_count >= lim) begin
          ovf_mid = 1'b1;
        end else begin
          emit_a        = 1'b1;
          ra.out_byte   = op_a.data;
          ra.byte_valid = 1'b1;
          cnt_mid       = line_count + CNT_W'(1);
        end
      end
      lts_pkg::OP_CLOSE: begin
        emit_a        = 1'b1;
        ra.line_done  = 1'b1;
        ra.terminator = op_a.term;
        ra.too_long   = overflowed;
        cnt_mid       = '0;
        ovf_mid       = 1'b0;
      end
      default: begin
      end
    endcase

    emit_b          = 1'b0;
    rb              = '0;
    line_count_next = cnt_mid;
    overflowed_next = ovf_mid;
    case (op_b.kind)
      lts_pkg::OP_CONTENT: begin
        if (ovf_mid || cnt_mid >= lim) begin
          overflowed_next = 1'b1;
        end else begin
          emit_b          = 1'b1;
          rb.out_byte     = op_b.data;
          rb.byte_valid   = 1'b1;
          line_count_next = cnt_mid + CNT_W'(1);
        end
      end
      lts_pkg::OP_CLOSE: begin
        emit_b          = 1'b1;
        rb.line_done    = 1'b1;
        rb.terminator   = op_b.term;
        rb.too_long     = ovf_mid;
        line_count_next = '0;
        overflowed_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Pack emitted results to the front and mark the final one
  always_comb begin
    res0      = emit_a ? ra : rb;
    res0.last = !(emit_a && emit_b);
    res1      = rb;
    res1.last = 1'b1;
    push0     = emit_a || emit_b;
    push1     = emit_a && emit_b;
  end

endmodule

`default_nettype wire

@@ rtl/core/lts_fifo.sv @@
// Small result queue that takes up to two words per cycle and gives one.
`default_nettype none

module lts_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push0,
  input  logic             push1,
  input  lts_pkg::result_t d0,
  input  lts_pkg::result_t d1,
  input  logic             pop,
  output lts_pkg::result_t head,
  output logic             not_empty,
  output logic             room2
);

  lts_pkg::result_t               mem [lts_pkg::FIFO_DEPTH];
  logic [lts_pkg::FIFO_AW-1:0]    wr_ptr;
  logic [lts_pkg::FIFO_AW-1:0]    rd_ptr;
  logic [lts_pkg::FIFO_AW:0]      count;
  logic [lts_pkg::FIFO_AW:0]      count_next;
  logic                           do_pop;

  assign do_pop    = pop && not_empty;
  assign not_empty = (count != '0);
  assign room2     = (count <= (lts_pkg::FIFO_AW + 1)'(lts_pkg::FIFO_DEPTH - 2));
  assign head      = mem[rd_ptr];

  always_comb begin
    count_next = count + (lts_pkg::FIFO_AW + 1)'(push0) + (lts_pkg::FIFO_AW + 1)'(push1)
               - (lts_pkg::FIFO_AW + 1)'(do_pop);
  end

  // Store new words at the write pointer
  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wr_ptr] <= d0;
    end
    if (push1) begin
      mem[wr_ptr + lts_pkg::FIFO_AW'(1)] <= d1;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + lts_pkg::FIFO_AW'(push0) + lts_pkg::FIFO_AW'(push1);
      rd_ptr <= rd_ptr + lts_pkg::FIFO_AW'(do_pop);
      count  <= count_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/line_terminator_splitter.sv @@
// Top level of the line splitter: byte stream in, content and line-close words out.
//
// Input channel s_*: one byte per word in s_tdata, s_tuser high marks end of
// stream (the byte is then ignored). Output channel m_*: each word is either a
// content byte or a line close with its terminator kind; m_tlast marks the
// final word caused by one input word. Terminators are stripped, a CR is held
// to look for a following LF, content past the line limit is dropped.
// Configuration channel cfg_*: index 0 accept_mask, index 1 line_limit; write
// only while the block is idle. cfg_ready is always high.
// Results of a word are registered in the result queue before they appear on m_*.
// Throughput: one input word per cycle while each word yields at most one
// result and the receiver is ready; a word that yields two results puts two words
// through the single output port that drains the four-entry result queue.
// Reset (synchronous) clears the held CR, line count, overflow flag and the
// queue, and restores accept_mask 7 and line_limit 8191.
// When the receiver stalls, the queue fills and s_tready drops once fewer
// than two free entries remain; no word is lost.
`default_nettype none

module line_terminator_splitter #(
  parameter int MAX_LINE = 8192
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] in_byte
  input  logic                            s_tuser,   // [0] end_of_stream
  // Output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,   // [7:0] out_byte
  output logic [4:0]                      m_tuser,   // [0] byte_valid, [1] line_done,
                                                     // [3:2] terminator, [4] too_long
  output logic                            m_tlast,   // last
  // Configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [12:0]                     cfg_data
);

  localparam int CNT_W = $clog2(MAX_LINE);

  logic [2:0]       accept_mask;
  logic [12:0]      line_limit;
  logic             pending_cr;
  logic [CNT_W-1:0] line_count;
  logic             overflowed;
  logic             pending_cr_next;
  logic [CNT_W-1:0] line_count_next;
  logic             overflowed_next;
  lts_pkg::result_t res0;
  lts_pkg::result_t res1;
  lts_pkg::result_t head;
  logic             push0;
  logic             push1;
  logic             room2;
  logic             in_fire;

  assign cfg_ready = 1'b1;
  assign s_tready  = room2;
  assign in_fire   = s_tvalid && s_tready;

  // Decode the incoming word
  lts_step #(
    .MAX_LINE (MAX_LINE),
    .CNT_W    (CNT_W)
  ) u_step (
    .in_byte         (s_tdata),
    .end_of_stream   (s_tuser),
    .accept_mask     (accept_mask),
    .line_limit      (line_limit),
    .pending_cr      (pending_cr),
    .line_count      (line_count),
    .overflowed      (overflowed),
    .pending_cr_next (pending_cr_next),
    .line_count_next (line_count_next),
    .overflowed_next (overflowed_next),
    .res0            (res0),
    .res1            (res1),
    .push0           (push0),
    .push1           (push1)
  );

  // Queue results for the output side
  lts_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push0     (push0 && in_fire),
    .push1     (push1 && in_fire),
    .d0        (res0),
    .d1        (res1),
    .pop       (m_tready),
    .head      (head),
    .not_empty (m_tvalid),
    .room2     (room2)
  );

  assign m_tdata = head.out_byte;
  assign m_tuser = {head.too_long, head.terminator, head.line_done, head.byte_valid};
  assign m_tlast = head.last;

  // Advance line state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_cr <= 1'b0;
      line_count <= '0;
      overflowed <= 1'b0;
    end else if (in_fire) begin
      pending_cr <= pending_cr_next;
      line_count <= line_count_next;
      overflowed <= overflowed_next;
    end
  end

  // Take configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      accept_mask <= lts_pkg::ACCEPT_MASK_RST;
      line_limit  <= lts_pkg::LINE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lts_pkg::REG_ACCEPT_MASK: accept_mask <= cfg_data[2:0];
        lts_pkg::REG_LINE_LIMIT:  line_limit  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lts_checker.sv @@
// Port-level checks for the line splitter and their bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module lts_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [4:0] m_tuser
);

  // Hold a stalled output word
  `LTS_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output word changed while stalled")

  // Each word is a content byte or a line close, never both
  `LTS_ASSERT(a_kind_one, clk, rst, m_tvalid |-> (m_tuser[0] ^ m_tuser[1]), "word is neither or both of content and close")

  // Content words carry no terminator and no overflow flag
  `LTS_ASSERT(a_content_clean, clk, rst, m_tvalid && m_tuser[0] |-> m_tuser[4:2] == 3'b000, "content word carries close fields")

  // Close words carry a zero byte
  `LTS_ASSERT(a_close_zero, clk, rst, m_tvalid && m_tuser[1] |-> m_tdata == 8'h00, "close word carries a byte")

  // Queue is empty after reset
  `LTS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "output valid right after reset")

endmodule

bind line_terminator_splitter lts_checker u_lts_checker (.*);

`default_nettype wire

@@ tb/sv/line_terminator_splitter_tb.sv @@
// Self-checking testbench for the line splitter: directed table, then randomized line traffic.
`timescale 1ns / 1ps

module line_terminator_splitter_tb;

  localparam int MAX_LINE      = 8192;
  localparam int LINE_CAP      = MAX_LINE - 1;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 120;
  localparam int HOLD_AT_WORD  = 400;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_COUNT   = 13;
  localparam int PHASE_ITEMS   = 100;
  localparam int PRINT_LIMIT   = 40;

  localparam logic [3:0] REG_UNUSED = 4'd15;

  typedef enum logic [1:0] {ROW_DATA, ROW_EOS, ROW_CFG} row_kind_t;
  // How a stimulus row is checked: by the predictor, no result, or one typed result
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} chk_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [3:0]        idx;
    logic [12:0]       value;
    chk_t              chk;
    lts_pkg::result_t  want;
  } row_t;

  typedef struct packed {
    logic [3:0]  idx;
    logic [12:0] data;
  } reg_write_t;

  function automatic lts_pkg::result_t content_word(input logic [7:0] b);
    content_word = '{b, 1'b1, 1'b0, lts_pkg::TERM_NONE, 1'b0, 1'b1};
  endfunction

  function automatic lts_pkg::result_t close_word(input logic [1:0] term, input logic tl);
    close_word = '{8'h00, 1'b0, 1'b1, term, tl, 1'b1};
  endfunction

  localparam int DIR_ROW_COUNT = 37;
  localparam row_t DIR_ROWS [DIR_ROW_COUNT] = '{
    // default terminators, full limit
    '{ROW_DATA, 4'd0, 13'h041, CHK_ONE,   content_word(8'h41)},
    '{ROW_DATA, 4'd0, 13'h00D, CHK_NONE,  '0},
    '{ROW_DATA, 4'd0, 13'h00A, CHK_ONE,   close_word(lts_pkg::TERM_CRLF, 1'b0)},
    '{ROW_DATA, 4'd0, 13'h000, CHK_ONE,   content_word(8'h00)},
    '{ROW_DATA, 4'd0, 13'h0FF, CHK_ONE,   content_word(8'hFF)},
    // held CR followed by other data, then by another CR, then end of stream
    '{ROW_DATA, 4'd0, 13'h00D, CHK_NONE,  '0},
    '{ROW_DATA, 4'd0, 13'h042, CHK_MODEL, '0},
    '{ROW_DATA, 4'd0, 13'h00D, CHK_MODEL, '0},
    '{ROW_DATA, 4'd0, 13'h00D, CHK_MODEL, '0},
    '{ROW_EOS,  4'd0, 13'h000, CHK_MODEL, '0},
    '{ROW_DATA, 4'd0, 13'h043, CHK_MODEL, '0},
    '{ROW_EOS,  4'd0, 13'h0FF, CHK_ONE,   close_word(lts_pkg::TERM_NONE, 1'b0)},
    '{ROW_EOS,  4'd0, 13'h000, CHK_NONE,  '0},
    // LF only, limit 2: CR is content, third byte overflows
    '{ROW_CFG,  lts_pkg::REG_ACCEPT_MASK, 13'h1FFA, CHK_MODEL, '0},
    '{ROW_CFG,  lts_pkg::REG_LINE_LIMIT,  13'd2,    CHK_MODEL, '0},
    '{ROW_DATA, 4'd0, 13'h00D, CHK_MODEL, '0},
    '{ROW_DATA, 4'd0, 13'h078, CHK_MODEL, '0},
    '{ROW_DATA, 4'd0, 13'h079, CHK_NONE,  '0},
    '{ROW_DATA, 4'd0, 13'h00A, CHK_ONE,   close_word(lts_pkg::TERM_LF, 1'b1)},
    // bare CR only, limit zero: every content byte drops
    '{ROW_CFG,  lts_pkg::REG_ACCEPT_MASK, 13'd1,    CHK_MODEL, '0},
    '{ROW_CFG,  lts_pkg::REG_LINE_LIMIT,  13'd0,    CHK_MODEL, '0},
    '{ROW_DATA, 4'd0, 13'h07A, CHK_NONE,  '0},
    '{ROW_DATA, 4'd0, 13'h00D, CHK_ONE,   close_word(lts_pkg::TERM_CR, 1'b1)},
    '{ROW_DATA, 4'd0, 13'h00A, CHK_NONE,  '0},
    '{ROW_EOS,  4'd0, 13'h000, CHK_ONE,   close_word(lts_pkg::TERM_NONE, 1'b1)},
    // no terminators, full limit, write to an unused index
    '{ROW_CFG,  lts_pkg::REG_ACCEPT_MASK, 13'd0,    CHK_MODEL, '0},
    '{ROW_CFG,  lts_pkg::REG_LINE_LIMIT,  13'h1FFF, CHK_MODEL, '0},
    '{ROW_CFG,  REG_UNUSED,               13'h1FFF, CHK_MODEL, '0},
    '{ROW_DATA, 4'd0, 13'h00D, CHK_MODEL, '0},
    '{ROW_DATA, 4'd0, 13'h00A, CHK_MODEL, '0},
    // CRLF only: held CR turns to content; mask change while CR is held
    '{ROW_CFG,  lts_pkg::REG_ACCEPT_MASK, 13'd4,    CHK_MODEL, '0},
    '{ROW_DATA, 4'd0, 13'h00D, CHK_NONE,  '0},
    '{ROW_DATA, 4'd0, 13'h071, CHK_MODEL, '0},
    '{ROW_DATA, 4'd0, 13'h00D, CHK_NONE,  '0},
    '{ROW_CFG,  lts_pkg::REG_ACCEPT_MASK, 13'd0,    CHK_MODEL, '0},
    '{ROW_DATA, 4'd0, 13'h00A, CHK_ONE,   close_word(lts_pkg::TERM_CRLF, 1'b0)},
    '{ROW_EOS,  4'd0, 13'h000, CHK_MODEL, '0}
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // [7:0] in_byte
  logic        s_tuser;    // [0] end_of_stream
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;    // [7:0] out_byte
  logic [4:0]  m_tuser;    // [0] byte_valid, [1] line_done, [3:2] terminator, [4] too_long
  logic        m_tlast;    // last
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [12:0] cfg_data;

  // Shadow of the splitter state and registers
  logic [2:0]  mask_shadow;
  logic [12:0] limit_shadow;
  logic        cr_held;
  int          kept_count;
  logic        dropping;

  lts_pkg::result_t step_words[$];
  lts_pkg::result_t awaited_words[$];
  reg_write_t       reg_writes[$];

  int          mismatches;
  int          words_seen;
  int          items_sent;
  int          reg_batches;
  int          idle_cycles;
  bit          src_idle;
  bit          sink_idle;
  bit          hold_done;

  line_terminator_splitter #(.MAX_LINE(MAX_LINE)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------- predictor ----------------

  function automatic void push_word(input logic [7:0] b, input logic v, input logic d,
                                    input logic [1:0] term, input logic tl);
    step_words.push_back('{b, v, d, term, tl, 1'b0});
  endfunction

  // Keep a content byte, or drop it once the line holds the limit
  function automatic void keep_content(input logic [7:0] b);
    int cap;
    cap = (int'(limit_shadow) < LINE_CAP) ? int'(limit_shadow) : LINE_CAP;
    if (dropping || kept_count >= cap) begin
      dropping = 1'b1;
    end else begin
      push_word(b, 1'b1, 1'b0, lts_pkg::TERM_NONE, 1'b0);
      kept_count++;
    end
  endfunction

  function automatic void close_line(input logic [1:0] term);
    push_word(8'h00, 1'b0, 1'b1, term, dropping);
    kept_count = 0;
    dropping   = 1'b0;
  endfunction

  // Resolve a held CR that is not followed by LF
  function automatic void resolve_cr();
    if (mask_shadow[lts_pkg::ACC_CR]) close_line(lts_pkg::TERM_CR);
    else keep_content(lts_pkg::CH_CR);
  endfunction

  function automatic void take_byte(input logic [7:0] b);
    if (b == lts_pkg::CH_CR &&
        (mask_shadow[lts_pkg::ACC_CR] || mask_shadow[lts_pkg::ACC_CRLF])) begin
      if (mask_shadow[lts_pkg::ACC_CRLF]) cr_held = 1'b1;
      else close_line(lts_pkg::TERM_CR);
    end else if (b == lts_pkg::CH_LF && mask_shadow[lts_pkg::ACC_LF]) begin
      close_line(lts_pkg::TERM_LF);
    end else begin
      keep_content(b);
    end
  endfunction

  // Work out the result words one input word causes, into step_words
  function automatic void predict_line_words(input logic [7:0] b, input logic eos);
    step_words.delete();
    if (eos) begin
      if (cr_held) begin
        cr_held = 1'b0;
        resolve_cr();
      end
      if (kept_count > 0 || dropping) close_line(lts_pkg::TERM_NONE);
    end else if (cr_held) begin
      cr_held = 1'b0;
      if (b == lts_pkg::CH_LF) begin
        close_line(lts_pkg::TERM_CRLF);
      end else begin
        resolve_cr();
        take_byte(b);
      end
    end else begin
      take_byte(b);
    end
    if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
  endfunction

  function automatic void apply_reg(input logic [3:0] idx, input logic [12:0] data);
    if (idx == lts_pkg::REG_ACCEPT_MASK) mask_shadow = data[2:0];
    else if (idx == lts_pkg::REG_LINE_LIMIT) limit_shadow = data;
  endfunction

  // ---------------- stimulus helpers ----------------

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 1;
    if (r < 95) return $urandom_range(2, 4);
    return $urandom_range(10, 30);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_LIMIT)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h (result word %0d)",
               $realtime, what, got, want, words_seen);
    mismatches++;
  endtask

  // Offer one input word, hold it until accepted, then record its expected results.
  // Valid stays high on return so the next word can follow without a bubble.
  task automatic send_word(input logic [7:0] b, input logic eos,
                           input chk_t chk = CHK_MODEL,
                           input lts_pkg::result_t want = '0);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= eos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    predict_line_words(b, eos);
    case (chk)
      CHK_MODEL: foreach (step_words[i]) awaited_words.push_back(step_words[i]);
      CHK_ONE:   awaited_words.push_back(want);
      default:   ;
    endcase
  endtask

  // Stop offering, drain every expected word, then let the pipeline settle
  task automatic wait_idle(input int settle);
    s_tvalid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Write the queued registers back to back with valid held high
  task automatic program_regs();
    wait_idle(SETTLE_CYCLES);
    foreach (reg_writes[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_writes[i].idx;
      cfg_data  <= reg_writes[i].data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      apply_reg(reg_writes[i].idx, reg_writes[i].data);
    end
    cfg_valid <= 1'b0;
    reg_writes.delete();
    reg_batches++;
  endtask

  function automatic logic [12:0] random_limit();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 13'($urandom_range(1, 8));
    if (r < 75) return 13'd0;
    if (r < 90) return 13'h1FFF;
    return 13'($urandom_range(9, 8190));
  endfunction

  // Mostly well-formed lines with random content, the rest loose terminators and noise
  task automatic run_line_traffic(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 75) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
        for (int k = 0; k < len; k++) send_word(8'($urandom_range(0, 255)), 1'b0);
        sent += len;
        case ($urandom_range(0, 3))
          0: send_word(lts_pkg::CH_CR, 1'b0);
          1: send_word(lts_pkg::CH_LF, 1'b0);
          2: begin
            send_word(lts_pkg::CH_CR, 1'b0);
            send_word(lts_pkg::CH_LF, 1'b0);
            sent++;
          end
          default: send_word(8'($urandom_range(0, 255)), 1'b1);
        endcase
        sent++;
      end else begin
        case ($urandom_range(0, 3))
          0: send_word(lts_pkg::CH_CR, 1'b0);
          1: send_word(lts_pkg::CH_LF, 1'b0);
          2: send_word(8'($urandom_range(0, 255)), 1'b0);
          default: send_word(8'($urandom_range(0, 255)), 1'b1);
        endcase
        sent++;
      end
    end
  endtask

  // ---------------- main sequence ----------------

  initial begin
    logic [2:0]  mask;
    logic [12:0] limit;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= 8'h00;
    s_tuser   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    mask_shadow  = lts_pkg::ACCEPT_MASK_RST;
    limit_shadow = lts_pkg::LINE_LIMIT_RST;
    cr_held      = 1'b0;
    kept_count   = 0;
    dropping     = 1'b0;
    mismatches   = 0;
    items_sent   = 0;
    reg_batches  = 0;
    src_idle     = 1'b1;
    sink_idle    = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; register rows collect and are written when the block is idle
    for (int i = 0; i < DIR_ROW_COUNT; i++) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        reg_writes.push_back('{DIR_ROWS[i].idx, DIR_ROWS[i].value});
      end else begin
        if (reg_writes.size() != 0) program_regs();
        send_word(DIR_ROWS[i].value[7:0], DIR_ROWS[i].kind == ROW_EOS,
                  DIR_ROWS[i].chk, DIR_ROWS[i].want);
      end
    end

    // Random phases, the first few pinned to extreme settings
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin mask = 3'd7; limit = 13'h1FFF; end
        1: begin mask = 3'd0; limit = 13'd1;    end
        2: begin mask = 3'd7; limit = 13'd0;    end
        3: begin mask = 3'd4; limit = 13'd3;    end
        4: begin mask = 3'd3; limit = 13'd5;    end
        default: begin
          mask  = 3'($urandom_range(0, 7));
          limit = random_limit();
        end
      endcase
      reg_writes.push_back('{lts_pkg::REG_ACCEPT_MASK,
                             13'(($urandom_range(0, 1023) << 3) | mask)});
      reg_writes.push_back('{lts_pkg::REG_LINE_LIMIT, limit});
      if ($urandom_range(0, 3) == 0)
        reg_writes.push_back('{4'($urandom_range(2, 15)), 13'($urandom_range(0, 8191))});
      program_regs();
      src_idle  = (p % 3) != 0;
      sink_idle = (p % 4) != 1;
      run_line_traffic(PHASE_ITEMS);
    end

    wait_idle(SETTLE_CYCLES * 2);
    $display("Sent %0d input words over %0d setting changes; checked %0d result words.",
             items_sent, reg_batches, words_seen);
    $display("Covered CR, LF and CRLF masks, held CR, overflow, zero limit, end of stream.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // ---------------- receiver ----------------

  // Random back-pressure, plus one long hold-off to fill the result queue
  initial begin
    m_tready  <= 1'b0;
    hold_done  = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && words_seen >= HOLD_AT_WORD) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (sink_idle && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Compare each accepted result word with the oldest expectation
  initial words_seen = 0;

  always @(posedge clk) begin : result_check
    lts_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_words.size() == 0) begin
        report_mismatch("unexpected word", {m_tuser, m_tlast, m_tdata}, 0);
      end else begin
        want = awaited_words.pop_front();
        if (m_tdata != want.out_byte)     report_mismatch("out_byte", m_tdata, want.out_byte);
        if (m_tuser[0] != want.byte_valid)
          report_mismatch("byte_valid", m_tuser[0], want.byte_valid);
        if (m_tuser[1] != want.line_done)
          report_mismatch("line_done", m_tuser[1], want.line_done);
        if (m_tuser[3:2] != want.terminator)
          report_mismatch("terminator", m_tuser[3:2], want.terminator);
        if (m_tuser[4] != want.too_long)  report_mismatch("too_long", m_tuser[4], want.too_long);
        if (m_tlast != want.last)         report_mismatch("last", m_tlast, want.last);
      end
      words_seen++;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial idle_cycles = 0;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, awaited_words.size());
      $display("FAILURE");
      $finish;
    end
  end

endmodule
